// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file cfip_checker.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication check with a label and a message.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication check.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== hw/rtl/cfip_pkg.sv =====
// Package for the clamped float integer power block.
// Holds the float constants; no dependencies.
package cfip_pkg;
   localparam logic [31:0] ONE_BITS   = 32'h3F80_0000;
   localparam logic [31:0] LIMIT_BITS = 32'h411F_FFFF; // 9.999999f
   localparam logic [31:0] QNAN_BITS  = 32'h7FC0_0000;
endpackage

// ===== hw/rtl/clamped_float_integer_power.sv =====
// Clamped float integer power: one IEEE single base and a signed exponent per word,
// result is base multiplied by itself power-1 times for power >= 1, 1.0 for power 0
// and the base itself for a negative power, clamped at 9.999999. Uses cfip_pkg.
// Each multiply runs through the single shared 24x24 multiplier with its normalise
// and round steps. Not ready while a word is in work.
module clamped_float_integer_power #(
   parameter int EXP_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // [31:0] base_value, [31+EXP_BITS:32] power, zero padded to bytes
   input  logic [((32+EXP_BITS+7)/8)*8-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // [31:0] clamped_result
   output logic [31:0]         rsp_tdata
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_UNPACK, ST_MUL, ST_ROUND, ST_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [31:0]         base_ff, base_in;
   logic [31:0]         acc_ff, acc_in;
   logic [EXP_BITS-1:0] left_ff, left_in;
   logic [47:0]         prod_ff, prod_in;
   logic signed [10:0]  exp_ff, exp_in;
   logic                sgn_ff, sgn_in;
   logic                spec_ff, spec_in;
   logic [31:0]         spec_val_ff, spec_val_in;
   logic [31:0]         out_ff, out_in;
   logic                ovalid_ff, ovalid_in;
   logic [49:0]         sig_ff, sig_in; // normalised: hidden at 49, grs below

   logic [31:0] req_base;
   logic signed [EXP_BITS-1:0] req_pow;
   assign req_base = req_tdata[31:0];
   assign req_pow  = req_tdata[32 +: EXP_BITS];

   // operand decode
   logic [7:0]  ea, eb;
   logic [22:0] fa, fb;
   logic [23:0] ma, mb;
   logic signed [10:0] ua, ub;
   logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   always_comb begin
      ea = acc_ff[30:23];  fa = acc_ff[22:0];
      eb = base_ff[30:23]; fb = base_ff[22:0];
      ma = {(ea != 8'd0), fa};
      mb = {(eb != 8'd0), fb};
      ua = (ea == 8'd0) ? 11'sd1 : $signed({3'd0, ea});
      ub = (eb == 8'd0) ? 11'sd1 : $signed({3'd0, eb});
      a_nan = (ea == 8'hFF) && (fa != 23'd0);
      b_nan = (eb == 8'hFF) && (fb != 23'd0);
      a_inf = (ea == 8'hFF) && (fa == 23'd0);
      b_inf = (eb == 8'hFF) && (fb == 23'd0);
      a_zero = (ea == 8'd0) && (fa == 23'd0);
      b_zero = (eb == 8'd0) && (fb == 23'd0);
   end

   // leading-zero count of the raw product (bounded priority scan)
   logic [5:0] lz;
   always_comb begin
      lz = 6'd48;
      for (int i = 0; i < 48; i++) begin
         if (prod_ff[i]) lz = 6'(47 - i);
      end
   end

   // rounding step inputs
   logic signed [10:0] re;
   logic [24:0] rm;
   logic [23:0] keep;
   logic        g, st, rup;
   logic [31:0] rounded;
   always_comb begin
      keep = sig_ff[49:26];
      g    = sig_ff[25];
      st   = |sig_ff[24:0];
      rup  = g && (st || keep[0]);
      rm   = {1'b0, keep} + {24'd0, rup};
      re   = exp_ff;
      if (rm[24]) begin
         re = exp_ff + 11'sd1;
      end
      if (re >= 11'sd255) begin
         rounded = {sgn_ff, 8'hFF, 23'd0};
      end else if (exp_ff == 11'sd0) begin
         // subnormal: a carry into the hidden bit gives the smallest normal
         rounded = {sgn_ff, 7'd0, rm[23:0]};
      end else begin
         rounded = {sgn_ff, re[7:0], rm[22:0]};
      end
   end

   // clamp: positive, not NaN, above limit
   function automatic logic [31:0] clampf(input logic [31:0] v);
      logic over;
      over = !v[31] && (v[30:0] > cfip_pkg::LIMIT_BITS[30:0])
             && !((v[30:23] == 8'hFF) && (v[22:0] != 23'd0));
      return over ? cfip_pkg::LIMIT_BITS : v;
   endfunction

   logic signed [10:0] e_norm;
   logic [49:0] sh_sig;
   logic [5:0]  rsh;
   always_comb begin
      // exponent with hidden bit placed at 49 after the left shift by lz
      e_norm = exp_ff + 11'sd1 - $signed({5'd0, lz});
      sh_sig = {prod_ff, 2'b00} << lz; // leading one now at bit 49
      rsh = 6'd0;
      if (e_norm < 11'sd1) begin
         rsh = (e_norm < -11'sd48) ? 6'd50 : 6'(11'sd1 - e_norm);
      end
   end

   always_comb begin
      state_in = state_ff; base_in = base_ff; acc_in = acc_ff; left_in = left_ff;
      prod_in = prod_ff; exp_in = exp_ff; sgn_in = sgn_ff; spec_in = spec_ff;
      spec_val_in = spec_val_ff; out_in = out_ff; ovalid_in = ovalid_ff;
      sig_in = sig_ff;
      if (ovalid_ff && rsp_tready) ovalid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               base_in = req_base;
               acc_in  = req_base;
               if (req_pow == '0) begin
                  acc_in = cfip_pkg::ONE_BITS;
                  state_in = ST_DONE;
                  left_in = '0;
               end else if (req_pow[EXP_BITS-1]) begin
                  left_in = '0;
                  state_in = ST_DONE;
               end else begin
                  left_in = EXP_BITS'(req_pow - 1'b1);
                  state_in = ST_DONE;
               end
            end
         end
         ST_UNPACK: begin
            // one multiplier pass: specials, sign, exponent, mantissa product
            sgn_in  = acc_ff[31] ^ base_ff[31];
            spec_in = 1'b1;
            if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
               spec_val_in = a_nan ? (acc_ff | 32'h0040_0000)
                           : b_nan ? (base_ff | 32'h0040_0000) : cfip_pkg::QNAN_BITS;
            end else if (a_inf || b_inf) begin
               spec_val_in = {sgn_in, 8'hFF, 23'd0};
            end else if (a_zero || b_zero) begin
               spec_val_in = {sgn_in, 31'd0};
            end else begin
               spec_in = 1'b0;
            end
            prod_in = ma * mb;
            exp_in  = ua + ub - 11'sd127;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            sig_in = (rsh >= 6'd50) ? {49'd0, |sh_sig}
                   : ((sh_sig >> rsh) | {49'd0, |(sh_sig & ~({50{1'b1}} << rsh))});
            exp_in = (rsh != 6'd0) ? 11'sd0 : e_norm;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            acc_in  = spec_ff ? spec_val_ff : rounded;
            left_in = left_ff - 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (left_ff != '0) begin
               state_in = ST_UNPACK;
            end else if (!ovalid_in) begin
               out_in = (acc_ff == cfip_pkg::ONE_BITS && base_ff != acc_ff)
                        ? acc_ff : clampf(acc_ff);
               ovalid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ovalid_ff <= 1'b0;
         left_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
         left_ff   <= left_in;
      end
      base_ff <= base_in; acc_ff <= acc_in; prod_ff <= prod_in; exp_ff <= exp_in;
      sgn_ff <= sgn_in; spec_ff <= spec_in; spec_val_ff <= spec_val_in;
      out_ff <= out_in; sig_ff <= sig_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = out_ff;
endmodule

// ===== hw/rtl/cfip_checker.sv =====
// Port checker for clamped_float_integer_power, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module cfip_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result word dropped while stalled")
   `CHK_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "took a second word while busy")
   `CHK_IMPL(a_clamp, clock, reset, rsp_tvalid && !rsp_tdata[31] && rsp_tdata[30:23] != 8'hFF, rsp_tdata[30:0] <= 31'h411F_FFFF || rsp_tdata == 32'h3F80_0000, "result above clamp")
endmodule

bind clamped_float_integer_power cfip_checker u_cfip_checker (.*);

// ===== verif/tb_clamped_float_integer_power.sv =====
// Self-checking bench for clamped_float_integer_power: an IEEE single repeated-multiply
// predictor, a burst driver, a stalling monitor. Depends on cfip_pkg and the block only.
module tb_clamped_float_integer_power;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int EXP_BITS = 8;
   localparam int DW = ((32+EXP_BITS+7)/8)*8;
   localparam int N_RANDOM = 1900;
   localparam int MAX_LAT = 506;

   typedef struct packed {
      logic [31:0]         base_value;
      logic [EXP_BITS-1:0] power;
   } pow_word_t;

   typedef struct packed {
      logic [31:0] bits;
      logic        any_nan; // multiplier NaN: payload left to the multiplier
   } pow_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [DW-1:0] req_tdata = '0;  // [31:0] base_value, [39:32] power
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [31:0] clamped_result

   clamped_float_integer_power #(.EXP_BITS(EXP_BITS)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pow_word_t   words_to_send[$];
   pow_result_t due_results[$];
   int errors = 0;
   int words_in = 0;
   int words_out = 0;
   int nan_seen = 0;
   int clamped_seen = 0;
   logic hold_off = 1'b0;

   // leading zeros of a 48-bit product
   function automatic int lead_zeros(logic [47:0] p);
      int n;
      n = 0;
      while (n < 48 && !p[47-n]) n++;
      return n;
   endfunction

   // one IEEE single multiply, round to nearest even, subnormals kept
   function automatic logic [32:0] fmul_rne(logic [31:0] a, logic [31:0] b);
      logic        s;
      logic [7:0]  ea, eb;
      logic [23:0] ma, mb;
      logic [47:0] p, q;
      logic [24:0] keep;
      logic [40:0] total;
      logic        guard, sticky;
      int e, sh, lz;
      s  = a[31] ^ b[31];
      ea = a[30:23];
      eb = b[30:23];
      // bit 32 flags a NaN produced here
      if ((ea == 8'hFF && a[22:0] != 0) || (eb == 8'hFF && b[22:0] != 0))
         return {1'b1, cfip_pkg::QNAN_BITS};
      if (ea == 8'hFF || eb == 8'hFF) begin
         if (a[30:0] == 0 || b[30:0] == 0) return {1'b1, cfip_pkg::QNAN_BITS};
         return {1'b0, s, 8'hFF, 23'd0};
      end
      if (a[30:0] == 0 || b[30:0] == 0) return {1'b0, s, 31'd0};
      ma = {ea != 0, a[22:0]};
      mb = {eb != 0, b[22:0]};
      p  = ma * mb;
      lz = lead_zeros(p);
      p  = p << lz;
      e  = int'(ea == 0 ? 1 : ea) + int'(eb == 0 ? 1 : eb) - 126 - lz;
      if (e >= 255) return {1'b0, s, 8'hFF, 23'd0};
      sh = (e < 1) ? 1 - e : 0;
      if (sh > 48) sh = 48;
      q = p >> sh;
      sticky = (sh == 0) ? 1'b0 : ((p & ((48'd1 << sh) - 48'd1)) != 0);
      guard  = q[23];
      sticky = sticky | (q[22:0] != 0);
      keep   = {1'b0, q[47:24]};
      if (guard && (sticky || keep[0])) keep = keep + 25'd1;
      // exponent field plus rounded significand: carries move into the exponent
      total = (41'((e >= 1) ? e - 1 : 0) << 23) + 41'(keep);
      if (total >= (41'hFF << 23)) return {1'b0, s, 8'hFF, 23'd0};
      return {1'b0, s, total[30:0]};
   endfunction

   // expected clamped power of one word
   function automatic pow_result_t power_predict(pow_word_t w);
      logic [31:0] acc;
      logic [32:0] prod;
      logic        mul_nan;
      int n;
      n = $signed(w.power);
      if (n == 0) return '{bits: cfip_pkg::ONE_BITS, any_nan: 1'b0};
      acc = w.base_value;
      mul_nan = 1'b0;
      for (int k = n - 1; k > 0; k--) begin
         prod = fmul_rne(acc, w.base_value);
         acc = prod[31:0];
         mul_nan = mul_nan | prod[32];
      end
      if (!acc[31] && acc[30:0] > cfip_pkg::LIMIT_BITS[30:0] &&
          !(acc[30:23] == 8'hFF && acc[22:0] != 0))
         acc = cfip_pkg::LIMIT_BITS;
      mul_nan = mul_nan && acc[30:23] == 8'hFF && acc[22:0] != 0;
      return '{bits: acc, any_nan: mul_nan};
   endfunction

   function automatic logic [31:0] rand_base();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2: begin
            // close to one so long powers stay finite
            return {1'($urandom), ($urandom_range(0, 1) ? 8'd127 : 8'd126), 23'($urandom)};
         end
         3: return {1'($urandom), 8'd0, 23'($urandom)};
         4: return {1'($urandom), 8'hFF, ($urandom_range(0, 1) ? 23'd0 : 23'($urandom))};
         5: return {1'($urandom), 8'($urandom_range(120, 131)), 23'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [EXP_BITS-1:0] rand_power();
      if ($urandom_range(0, 9) < 7) return EXP_BITS'($signed($urandom_range(0, 24)) - 8);
      return EXP_BITS'($urandom);
   endfunction

   // acceptance, prediction and result check at the rising edge
   logic req_taken = 1'b0;
   always @(posedge clock) begin
      pow_result_t want;
      pow_word_t   seen;
      req_taken <= (!reset && req_tvalid && req_tready);
      if (!reset && req_tvalid && req_tready) begin
         seen = '{base_value: req_tdata[31:0], power: req_tdata[32 +: EXP_BITS]};
         due_results.push_back(power_predict(seen));
         words_in++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_out++;
         if (due_results.size() == 0) begin
            $error("clamped_result: word 0x%08h with nothing expected", rsp_tdata);
            errors++;
         end else begin
            want = due_results.pop_front();
            if (want.any_nan ? !(rsp_tdata[30:23] == 8'hFF && rsp_tdata[22:0] != 0)
                             : rsp_tdata !== want.bits) begin
               $error("clamped_result: expected 0x%08h actual 0x%08h", want.bits, rsp_tdata);
               errors++;
            end
            if (rsp_tdata[30:23] == 8'hFF && rsp_tdata[22:0] != 0) nan_seen++;
            if (rsp_tdata == cfip_pkg::LIMIT_BITS) clamped_seen++;
         end
      end
   end

   // driver: bursts of words with random gaps, changes at the falling edge
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      pow_word_t w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         req_tvalid <= 1'b1;
      end else if (gap_left > 0) begin
         gap_left--;
         req_tvalid <= 1'b0;
      end else if (words_to_send.size() > 0) begin
         w = words_to_send.pop_front();
         req_tdata <= DW'({w.power, w.base_value});
         req_tvalid <= 1'b1;
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // receiver stall pattern, with one long hold-off
   int stall_phase = 0;
   always @(negedge clock) begin
      stall_phase = (stall_phase + 1) % 400;
      if (hold_off) rsp_tready <= 1'b0;
      else if (stall_phase < 100) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   initial begin
      wait (words_in >= 40);
      @(negedge clock);
      hold_off = 1'b1;
      repeat (3000) @(negedge clock);
      hold_off = 1'b0;
   end

   // directed words then random ones
   initial begin
      logic [31:0] b;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      words_to_send.push_back('{32'h7FC0_1234, 8'sd0});     // zero exponent on NaN
      words_to_send.push_back('{32'hFFFF_FFFF, 8'sd0});
      words_to_send.push_back('{32'h4120_0000, 8'sd1});     // 10.0 clamped
      words_to_send.push_back('{32'h411F_FFFF, 8'sd1});     // exactly the limit
      words_to_send.push_back('{32'h4120_0000, -8'sd1});    // negative acts as one
      words_to_send.push_back('{32'hC120_0000, 8'h80});     // most negative exponent
      words_to_send.push_back('{32'h7F80_0000, 8'sd1});     // +inf clamped
      words_to_send.push_back('{32'hFF80_0000, 8'sd3});     // -inf passes
      words_to_send.push_back('{32'h7FA0_0001, 8'sd1});     // NaN base untouched
      words_to_send.push_back('{32'h7FC0_0000, 8'sd4});     // NaN through multiplies
      words_to_send.push_back('{32'h3F80_0000, 8'sd127});
      words_to_send.push_back('{32'h3F80_0001, 8'sd127});
      words_to_send.push_back('{32'hBF7F_FFFF, 8'sd127});
      words_to_send.push_back('{32'h7F7F_FFFF, 8'sd2});     // overflow to inf, then clamped
      words_to_send.push_back('{32'h0000_0001, 8'sd2});     // subnormal underflow
      words_to_send.push_back('{32'h1F80_0000, 8'sd5});     // through subnormals to zero
      words_to_send.push_back('{32'h8000_0000, 8'sd3});
      words_to_send.push_back('{32'h0000_0000, 8'sd126});
      words_to_send.push_back('{32'h3FB5_04F3, 8'sd7});     // sqrt2: above the limit, clamped
      words_to_send.push_back('{32'h4000_0000, 8'sd4});
      words_to_send.push_back('{32'hC000_0000, 8'sd3});
      for (int i = 0; i < N_RANDOM; i++) begin
         b = rand_base();
         words_to_send.push_back('{b, rand_power()});
      end
      wait (words_to_send.size() == 0 && !req_tvalid);
      wait (due_results.size() == 0);
      repeat (MAX_LAT + 20) @(posedge clock);
      $display("Ran %0d words in, %0d results out, %0d NaN and %0d clamped results.",
               words_in, words_out, nan_seen, clamped_seen);
      if (errors == 0 && due_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #40ms;
      $display("FAIL");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/cfip_pkg.sv
hw/rtl/clamped_float_integer_power.sv
hw/rtl/cfip_checker.sv
verif/tb_clamped_float_integer_power.sv
